>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed: always");

// antecedent in one cycle implies consequent in the next
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next cycle");

`else

`define CHK_ALWAYS(label, clk, rst, prop)
`define CHK_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/u8sv_pkg.sv
// shared types, constants and helpers of the utf-8 stream validator
package u8sv_pkg;

   // width of the byte counters
   localparam int OFFSET_BITS = 32;
   localparam int RESULT_OFFSET_BITS = 32;
   localparam int CODE_BITS = 21;

   // sequence length classes
   localparam logic [1:0] CLASS_TWO   = 2'd0;
   localparam logic [1:0] CLASS_THREE = 2'd1;
   localparam logic [1:0] CLASS_FOUR  = 2'd2;

   // code point limits
   localparam logic [CODE_BITS-1:0] MIN_TWO       = 21'h00080;
   localparam logic [CODE_BITS-1:0] MIN_THREE     = 21'h00800;
   localparam logic [CODE_BITS-1:0] MIN_FOUR      = 21'h10000;
   localparam logic [CODE_BITS-1:0] MAX_CODE      = 21'h10FFFF;
   localparam logic [CODE_BITS-1:0] SURROGATE_LO  = 21'h0D800;
   localparam logic [CODE_BITS-1:0] SURROGATE_HI  = 21'h0DFFF;

   // one input word
   typedef struct packed {
      logic       last;
      logic [7:0] data_byte;
   } in_word_type;

   // one result word
   typedef struct packed {
      logic [RESULT_OFFSET_BITS-1:0] error_offset;
      logic                          valid_res;
   } rsp_word_type;

   // state summary seen by the top level
   typedef struct packed {
      logic seq_open;
      logic err_seen;
      logic at_start;
   } step_status_type;

   // smallest legal value for a length class
   function automatic logic [CODE_BITS-1:0] min_value(input logic [1:0] cls);
      logic [CODE_BITS-1:0] v;
      case (cls)
         CLASS_TWO:   v = MIN_TWO;
         CLASS_THREE: v = MIN_THREE;
         default:     v = MIN_FOUR;
      endcase
      return v;
   endfunction

   // overlong, out of range or surrogate
   function automatic logic bad_value(input logic [CODE_BITS-1:0] code,
                                      input logic [1:0] cls);
      return (code < min_value(cls)) || (code > MAX_CODE) ||
             ((code >= SURROGATE_LO) && (code <= SURROGATE_HI));
   endfunction

endpackage

>>> hdl/u8sv_in_reg.sv
// input register stage of the utf-8 stream validator
module u8sv_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,
   input  logic                 take,
   output logic                 word_valid,
   output u8sv_pkg::in_word_type word
);

   logic                  valid_ff;
   logic                  valid_in;
   u8sv_pkg::in_word_type word_ff;
   logic                  load;

   // stage is free when empty or drained this cycle
   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff.data_byte <= req_tdata;
         word_ff.last      <= req_tlast;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

>>> hdl/u8sv_step.sv
// per-byte decode and state update of the utf-8 stream validator
module u8sv_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  u8sv_pkg::in_word_type    word,
   output u8sv_pkg::rsp_word_type   result,
   output u8sv_pkg::step_status_type status
);

   localparam int OB = u8sv_pkg::OFFSET_BITS;
   localparam int CB = u8sv_pkg::CODE_BITS;

   logic [OB-1:0] byte_pos_ff, byte_pos_in;
   logic [OB-1:0] lead_pos_ff, lead_pos_in;
   logic [1:0]    expect_ff, expect_in;
   logic [CB-1:0] code_ff, code_in;
   logic [1:0]    class_ff, class_in;
   logic          err_ff, err_in;
   logic [OB-1:0] first_off_ff, first_off_in;
   logic          pend_ff, pend_in;
   logic [OB-1:0] pend_off_ff, pend_off_in;
   logic [7:0]    b;
   logic [CB-1:0] code_shift;

   assign b          = word.data_byte;
   assign code_shift = {code_ff[CB-7:0], b[5:0]};

   // decode one byte against the current state
   always_comb begin
      lead_pos_in  = lead_pos_ff;
      expect_in    = expect_ff;
      code_in      = code_ff;
      class_in     = class_ff;
      err_in       = err_ff;
      first_off_in = first_off_ff;
      pend_in      = pend_ff;
      pend_off_in  = pend_off_ff;
      byte_pos_in  = byte_pos_ff + OB'(1);

      if (!err_ff) begin
         if (expect_ff == 2'd0) begin
            // lead byte
            case (b) inside
               [8'h00:8'h7F]: begin
               end
               [8'hC0:8'hDF]: begin
                  lead_pos_in = byte_pos_ff;
                  expect_in   = 2'd1;
                  class_in    = u8sv_pkg::CLASS_TWO;
                  code_in     = CB'(b[4:0]);
                  pend_in     = 1'b0;
               end
               [8'hE0:8'hEF]: begin
                  lead_pos_in = byte_pos_ff;
                  expect_in   = 2'd2;
                  class_in    = u8sv_pkg::CLASS_THREE;
                  code_in     = CB'(b[3:0]);
                  pend_in     = 1'b0;
               end
               [8'hF0:8'hF7]: begin
                  lead_pos_in = byte_pos_ff;
                  expect_in   = 2'd3;
                  class_in    = u8sv_pkg::CLASS_FOUR;
                  code_in     = CB'(b[2:0]);
                  pend_in     = 1'b0;
               end
               default: begin
                  err_in       = 1'b1;
                  first_off_in = byte_pos_ff;
               end
            endcase
         end else begin
            // continuation byte, a bad one waits for the sequence end
            if (!pend_ff) begin
               if (b[7:6] != 2'b10) begin
                  pend_in     = 1'b1;
                  pend_off_in = byte_pos_ff;
               end else begin
                  code_in = code_shift;
               end
            end
            expect_in = expect_ff - 2'd1;
            if (expect_in == 2'd0) begin
               if (pend_in) begin
                  err_in       = 1'b1;
                  first_off_in = pend_off_in;
               end else if (u8sv_pkg::bad_value(code_in, class_ff)) begin
                  err_in       = 1'b1;
                  first_off_in = lead_pos_ff;
               end
               pend_in = 1'b0;
            end
         end
      end

      // text cut short inside a sequence
      if (word.last && !err_in && (expect_in != 2'd0)) begin
         err_in       = 1'b1;
         first_off_in = lead_pos_in;
      end
   end

   // result for a final byte
   always_comb begin
      result.valid_res    = !err_in;
      result.error_offset = err_in ? u8sv_pkg::RESULT_OFFSET_BITS'(first_off_in) : '0;
   end

   // state registers, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset || (advance && word.last)) begin
         byte_pos_ff  <= '0;
         lead_pos_ff  <= '0;
         expect_ff    <= '0;
         code_ff      <= '0;
         class_ff     <= '0;
         err_ff       <= 1'b0;
         first_off_ff <= '0;
         pend_ff      <= 1'b0;
         pend_off_ff  <= '0;
      end else if (advance) begin
         byte_pos_ff  <= byte_pos_in;
         lead_pos_ff  <= lead_pos_in;
         expect_ff    <= expect_in;
         code_ff      <= code_in;
         class_ff     <= class_in;
         err_ff       <= err_in;
         first_off_ff <= first_off_in;
         pend_ff      <= pend_in;
         pend_off_ff  <= pend_off_in;
      end
   end

   assign status.seq_open = (expect_ff != 2'd0);
   assign status.err_seen = err_ff;
   assign status.at_start = (byte_pos_ff == '0) && (expect_ff == 2'd0) && !err_ff && !pend_ff;

endmodule

>>> hdl/u8sv_out_reg.sv
// result register of the utf-8 stream validator
module u8sv_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  u8sv_pkg::rsp_word_type result,
   output logic                   slot_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata    // [0] valid_res, [32:1] error_offset, [39:33] zero
);

   logic                   valid_ff;
   logic                   valid_in;
   u8sv_pkg::rsp_word_type result_ff;

   // slot frees as the held word is taken
   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, result_ff};

endmodule

>>> hdl/utf8_stream_validator_top.sv
// utf-8 stream validator: one byte per word in, one verdict per text out
// path: a final byte passes the input register, then the result register, before its result shows on rsp
// throughput: one byte per cycle, set by the combinational decode between the
//   input register and the state registers; stalls only when the result slot is full
// reset: synchronous, active high; clears both stages and the text state
// after each final byte the state returns to offset zero for the next text
`include "assert_macros.svh"

module utf8_stream_validator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata     // [0] valid_res, [32:1] error_offset, [39:33] zero
);

   logic                      word_valid;
   u8sv_pkg::in_word_type     word;
   u8sv_pkg::rsp_word_type    result;
   u8sv_pkg::step_status_type status;
   logic                      slot_free;
   logic                      advance;

   // a word moves on unless it is final and the result slot is full
   assign advance = word_valid && (!word.last || slot_free);

   u8sv_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   u8sv_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (word),
      .result  (result),
      .status  (status)
   );

   u8sv_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && word.last),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // checks
   `CHK_NEXT(a_final_clears_state, clock, reset, advance && word.last, status.at_start)
   `CHK_ALWAYS(a_rsp_from_final, clock, reset, $rose(rsp_tvalid) |-> $past(advance && word.last))
   `CHK_ALWAYS(a_stall_only_when_held, clock, reset, !req_tready |-> (word_valid && !advance))
   `CHK_ALWAYS(a_no_open_after_error, clock, reset, !(status.err_seen && status.seq_open))

endmodule

>>> dv/testbench.sv
// self-checking testbench of the utf-8 stream validator: directed table, then random texts
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 400000;

   // one stimulus word with an optional hand-written verdict for the final byte
   typedef struct {
      logic [7:0]  data;
      logic        fin;
      bit          typed;
      logic        ok;
      logic [31:0] where;
   } octet_item_type;

   // verdict of one text
   typedef struct {
      logic        ok;
      logic [31:0] where;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [0] valid_res, [32:1] error_offset, [39:33] zero

   octet_item_type octet_q[$];
   verdict_type    verdict_q[$];
   int             fail_count = 0;
   int             seen = 0;
   int             send_idle = 24;
   int             recv_idle = 68;

   // predictor state of the text in progress
   logic [31:0]                    pos_cnt = '0;
   logic [31:0]                    lead_pos = '0;
   logic [1:0]                     cont_left = '0;
   logic [u8sv_pkg::CODE_BITS-1:0] code_acc = '0;
   logic [1:0]                     seq_class = u8sv_pkg::CLASS_TWO;
   logic                           err_flag = 1'b0;
   logic [31:0]                    err_off = '0;
   logic                           bad_cont_hold = 1'b0;
   logic [31:0]                    bad_cont_off = '0;

   utf8_stream_validator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // advance the predictor by one byte; done is set on the final byte of a text
   function automatic void utf8_advance(input logic [7:0] b, input logic fin,
                                        output bit done, output logic ok,
                                        output logic [31:0] where);
      logic [u8sv_pkg::CODE_BITS-1:0] floor_v;
      done = 1'b0;
      ok = 1'b0;
      where = '0;
      if (!err_flag) begin
         if (cont_left == 2'd0) begin
            // lead byte, ascii needs nothing
            if (b[7]) begin
               if (b[7:5] == 3'b110) begin
                  lead_pos = pos_cnt;
                  cont_left = 2'd1;
                  seq_class = u8sv_pkg::CLASS_TWO;
                  code_acc = {16'd0, b[4:0]};
                  bad_cont_hold = 1'b0;
               end else if (b[7:4] == 4'b1110) begin
                  lead_pos = pos_cnt;
                  cont_left = 2'd2;
                  seq_class = u8sv_pkg::CLASS_THREE;
                  code_acc = {17'd0, b[3:0]};
                  bad_cont_hold = 1'b0;
               end else if (b[7:3] == 5'b11110) begin
                  lead_pos = pos_cnt;
                  cont_left = 2'd3;
                  seq_class = u8sv_pkg::CLASS_FOUR;
                  code_acc = {18'd0, b[2:0]};
                  bad_cont_hold = 1'b0;
               end else begin
                  err_flag = 1'b1;
                  err_off = pos_cnt;
               end
            end
         end else begin
            // continuation byte, a bad one is held until the sequence closes
            if (!bad_cont_hold) begin
               if (b[7:6] != 2'b10) begin
                  bad_cont_hold = 1'b1;
                  bad_cont_off = pos_cnt;
               end else begin
                  code_acc = {code_acc[14:0], b[5:0]};
               end
            end
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               case (seq_class)
                  u8sv_pkg::CLASS_TWO:   floor_v = u8sv_pkg::MIN_TWO;
                  u8sv_pkg::CLASS_THREE: floor_v = u8sv_pkg::MIN_THREE;
                  default:               floor_v = u8sv_pkg::MIN_FOUR;
               endcase
               if (bad_cont_hold) begin
                  err_flag = 1'b1;
                  err_off = bad_cont_off;
               end else if (code_acc < floor_v || code_acc > u8sv_pkg::MAX_CODE ||
                            (code_acc >= u8sv_pkg::SURROGATE_LO &&
                             code_acc <= u8sv_pkg::SURROGATE_HI)) begin
                  err_flag = 1'b1;
                  err_off = lead_pos;
               end
               bad_cont_hold = 1'b0;
            end
         end
      end
      if (fin) begin
         // text cut short inside a sequence reports the lead
         if (!err_flag && cont_left != 2'd0) begin
            err_flag = 1'b1;
            err_off = lead_pos;
         end
         done = 1'b1;
         ok = !err_flag;
         where = err_flag ? err_off : 32'd0;
         pos_cnt = '0;
         lead_pos = '0;
         cont_left = '0;
         code_acc = '0;
         seq_class = u8sv_pkg::CLASS_TWO;
         err_flag = 1'b0;
         err_off = '0;
         bad_cont_hold = 1'b0;
         bad_cont_off = '0;
      end else begin
         pos_cnt = pos_cnt + 32'd1;
      end
   endfunction

   // one row of the directed table
   task automatic dir_row(input logic [7:0] b, input logic fin, input bit typed,
                          input logic ok, input logic [31:0] where);
      octet_q.push_back('{b, fin, typed, ok, where});
   endtask

   // one random text: mostly well-formed characters, some malformed or noise
   task automatic add_random_text();
      logic [7:0]  txt[$];
      logic [20:0] cp;
      int unsigned n_chars, nb, pick, cut;
      pick = $urandom_range(99);
      n_chars = $urandom_range(1, 8);
      if (pick < 6) begin
         repeat (n_chars) txt.push_back(8'($urandom));
      end else begin
         for (int k = 0; k < n_chars; k++) begin
            nb = $urandom_range(1, 4);
            case (nb)
               1: cp = 21'($urandom_range(0, 'h7F));
               2: cp = 21'($urandom_range('h80, 'h7FF));
               3: begin
                  cp = 21'($urandom_range('h800, 'hFFFF));
                  if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp - 21'h800;
               end
               default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
            // malformed values: overlong, surrogate, above range
            pick = $urandom_range(99);
            if (pick < 5) begin
               nb = $urandom_range(2, 4);
               cp = (nb == 2) ? 21'($urandom_range(0, 'h7F)) :
                    (nb == 3) ? 21'($urandom_range(0, 'h7FF)) :
                    21'($urandom_range(0, 'hFFFF));
            end else if (pick < 9) begin
               nb = 3;
               cp = 21'($urandom_range('hD800, 'hDFFF));
            end else if (pick < 13) begin
               nb = 4;
               cp = 21'($urandom_range('h110000, 'h1FFFFF));
            end
            case (nb)
               1: txt.push_back(cp[7:0]);
               2: begin
                  txt.push_back({3'b110, cp[10:6]});
                  txt.push_back({2'b10, cp[5:0]});
               end
               3: begin
                  txt.push_back({4'b1110, cp[15:12]});
                  txt.push_back({2'b10, cp[11:6]});
                  txt.push_back({2'b10, cp[5:0]});
               end
               default: begin
                  txt.push_back({5'b11110, cp[20:18]});
                  txt.push_back({2'b10, cp[17:12]});
                  txt.push_back({2'b10, cp[11:6]});
                  txt.push_back({2'b10, cp[5:0]});
               end
            endcase
         end
         // corrupt one byte, or cut the text short
         if ($urandom_range(99) < 14) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
         if ($urandom_range(99) < 12 && txt.size() > 1) begin
            cut = $urandom_range(1, (txt.size() > 3) ? 3 : txt.size() - 1);
            repeat (cut) void'(txt.pop_back());
         end
      end
      foreach (txt[i]) octet_q.push_back('{txt[i], i == txt.size() - 1, 1'b0, 1'b0, 32'd0});
   endtask

   // receiver side
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   // compare each result word with the oldest verdict, then predict from accepted words
   always @(posedge clock) begin : scoreboard
      u8sv_pkg::rsp_word_type got;
      verdict_type            want;
      bit                     done;
      logic                   ok;
      logic [31:0]            where;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[32:0];
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected result, expected none got valid_res %0d offset %0d",
                        $time, got.valid_res, got.error_offset);
               fail_count++;
            end else begin
               want = verdict_q.pop_front();
               if (got.valid_res !== want.ok) begin
                  $display("%0t: valid_res expected %0d got %0d", $time, want.ok,
                           got.valid_res);
                  fail_count++;
               end
               if (got.error_offset !== want.where) begin
                  $display("%0t: error_offset expected %0d got %0d", $time, want.where,
                           got.error_offset);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            utf8_advance(req_tdata, req_tlast, done, ok, where);
            if (done) begin
               if (octet_q[seen].typed)
                  verdict_q.push_back('{octet_q[seen].ok, octet_q[seen].where});
               else
                  verdict_q.push_back('{ok, where});
            end
            seen++;
         end
      end
   end

   // run watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("utf8_stream_validator_top regression: fail");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int sent;
      int total;
      // extremes, each error kind, truncation with and without a held bad continuation
      dir_row(8'h00, 1'b1, 1'b1, 1'b1, 32'd0);
      dir_row(8'h7F, 1'b1, 1'b1, 1'b1, 32'd0);
      dir_row(8'h80, 1'b1, 1'b1, 1'b0, 32'd0);
      dir_row(8'hFF, 1'b1, 1'b1, 1'b0, 32'd0);
      dir_row(8'hC2, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h80, 1'b1, 1'b0, 1'b0, 32'd0);
      dir_row(8'hC0, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h80, 1'b1, 1'b1, 1'b0, 32'd0);
      dir_row(8'hED, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'hA0, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h80, 1'b1, 1'b1, 1'b0, 32'd0);
      dir_row(8'hF4, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h90, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h80, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h80, 1'b1, 1'b1, 1'b0, 32'd0);
      dir_row(8'hE2, 1'b1, 1'b1, 1'b0, 32'd0);
      dir_row(8'hC3, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h41, 1'b1, 1'b1, 1'b0, 32'd1);
      dir_row(8'hE2, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h41, 1'b1, 1'b1, 1'b0, 32'd0);
      dir_row(8'hF0, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h9F, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h98, 1'b0, 1'b0, 1'b0, 32'd0);
      dir_row(8'h80, 1'b1, 1'b0, 1'b0, 32'd0);
      total = octet_q.size() + RANDOM_ITEMS;
      while (octet_q.size() < total) add_random_text();
      total = octet_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drive words; idling changes by thirds of the run
      sent = 0;
      while (sent < total) begin
         @(posedge clock);
         if (req_tvalid && req_tready) sent++;
         case (sent * 3 / total)
            0: begin send_idle = 24; recv_idle = 68; end
            1: begin send_idle = 68; recv_idle = 24; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         if (sent == total) begin
            req_tvalid <= 1'b0;
         end else if (!req_tvalid || req_tready) begin
            if ($urandom_range(99) < send_idle) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= octet_q[sent].data;
               req_tlast <= octet_q[sent].fin;
            end
         end
      end

      // drain, then idle before the final report
      while (verdict_q.size() != 0 || seen < total) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("utf8_stream_validator_top regression: pass");
      else
         $display("utf8_stream_validator_top regression: fail");
      $finish;
   end

endmodule
